// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Expect clk and rst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RTA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define RTA_ASSERT(lbl, prop)
`define RTA_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ===== sv/rta_pkg.sv =====
// Types and constants of the region table address translator.
// No dependencies.
`timescale 1ns / 1ps

package rta_pkg;

  localparam logic [63:0] ACCESS_BYTES = 64'd8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_UNBACKED = 2'd2,
    ST_LOADED   = 2'd3
  } rta_status_t;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_LOOKUP = 1'b1
  } rta_mode_t;

  typedef struct packed {
    logic        mode;
    logic [3:0]  entry_index;
    logic [63:0] region_start;
    logic [63:0] region_length;
    logic [63:0] backing_start;
    logic [63:0] backing_length;
    logic [63:0] query_address;
  } rta_in_t;

  typedef struct packed {
    rta_status_t status;
    logic [63:0] translated_offset;
    logic [3:0]  hit_slot;
  } rta_out_t;

  // Word traveling along the cell chain.
  typedef struct packed {
    logic        vld;
    rta_in_t     req;
    logic        hit;
    logic [3:0]  hit_slot;
    logic [63:0] offset;
    logic [63:0] limit;
  } rta_token_t;

endpackage

// ===== sv/region_table_address_translator.sv =====
// Top level of the region table address translator: cell chain plus output stage.
// Depends on rta_pkg, rta_cell and rta_result.
//
//   port group  direction  payload     handshake
//   in_         input      rta_in_t    in_valid / in_stall
//   out_        output     rta_out_t   out_valid / out_stall
//
// Every word, load or lookup, walks the row of TABLE_SLOTS cells, one cell a
// cycle while the chain advances, so words keep their order and a load lands
// in its cell in sequence. Throughput is one word per cycle when the output
// is not stalled; each word passes the TABLE_SLOTS cell registers, then the
// output register. Reset clears the slot valid bits and word valid flags.
// A stalled result freezes the whole chain and raises in_stall.
`timescale 1ns / 1ps

module region_table_address_translator #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rta_pkg::rta_in_t   in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output rta_pkg::rta_out_t  out_word
);
  import rta_pkg::*;

  rta_token_t tok [0:TABLE_SLOTS];
  logic       advance;

  always_comb begin
    tok[0]          = '0;
    tok[0].vld      = in_valid;
    tok[0].req      = in_word;
  end

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    rta_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  rta_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_in    (tok[TABLE_SLOTS]),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign in_stall = !advance;

endmodule

// ===== sv/rta_cell.sv =====
// One table slot of the chain: holds a region and checks passing lookups.
// Depends on rta_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rta_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  rta_pkg::rta_token_t tok_in,
  output rta_pkg::rta_token_t tok_out
);
  import rta_pkg::*;

  localparam bit [31:0] CellIdxW = CELL_IDX;
  localparam logic [3:0] CellSlot = CellIdxW[3:0];

  logic        valid_r;
  logic [63:0] lo_r;
  logic [63:0] hi_r;     // start + length, wrapped
  logic [63:0] delta_r;  // backing_start - start
  logic [63:0] lim_r;    // backing_start + backing_length
  rta_token_t  tok_r;
  rta_token_t  tok_nxt;

  logic is_load;
  logic slot_match;
  logic in_range;

  assign is_load    = tok_in.req.mode == MODE_LOAD;
  assign slot_match = 32'(tok_in.req.entry_index) == CellIdxW;
  assign in_range   = valid_r && (tok_in.req.query_address >= lo_r) &&
                      (tok_in.req.query_address < hi_r);

  always_comb begin
    tok_nxt = tok_in;
    // Lower slots win: take the hit only if nothing upstream matched.
    if (!is_load && !tok_in.hit && in_range) begin
      tok_nxt.hit      = 1'b1;
      tok_nxt.hit_slot = CellSlot;
      tok_nxt.offset   = tok_in.req.query_address + delta_r;
      tok_nxt.limit    = lim_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (advance) begin
      tok_r <= tok_nxt;
      if (tok_in.vld && is_load && slot_match) begin
        valid_r <= 1'b1;
        lo_r    <= tok_in.req.region_start;
        hi_r    <= tok_in.req.region_start + tok_in.req.region_length;
        delta_r <= tok_in.req.backing_start - tok_in.req.region_start;
        lim_r   <= tok_in.req.backing_start + tok_in.req.backing_length;
      end
    end
  end

  assign tok_out = tok_r;

  `RTA_ASSERT_IMP(a_hold_when_frozen, !advance, ##1 $stable(valid_r))
  `RTA_ASSERT_IMP(a_hit_keeps_slot, advance && tok_in.vld && tok_in.hit,
                  ##1 (tok_r.hit && tok_r.hit_slot == $past(tok_in.hit_slot)))
  `RTA_ASSERT_IMP(a_load_sets_valid,
                  advance && tok_in.vld && is_load && slot_match, ##1 valid_r)

endmodule

// ===== sv/rta_result.sv =====
// Output stage: backed-access check, status coding and the output register.
// Depends on rta_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rta_result (
  input  logic                clk,
  input  logic                rst_n,
  input  rta_pkg::rta_token_t tok_in,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output rta_pkg::rta_out_t   out_word
);
  import rta_pkg::*;

  logic     out_valid_r;
  rta_out_t out_word_r;
  rta_out_t out_word_nxt;

  // Move the whole chain only when the output register is empty or its word is being taken.
  assign advance = !out_valid_r || !out_stall;

  always_comb begin
    out_word_nxt.status            = ST_UNMAPPED;
    out_word_nxt.translated_offset = '0;
    out_word_nxt.hit_slot          = '0;
    if (tok_in.req.mode == MODE_LOAD) begin
      out_word_nxt.status   = ST_LOADED;
      out_word_nxt.hit_slot = tok_in.req.entry_index;
    end else if (tok_in.hit) begin
      out_word_nxt.status = ((tok_in.offset + ACCESS_BYTES) > tok_in.limit) ?
                            ST_UNBACKED : ST_OK;
      out_word_nxt.translated_offset = tok_in.offset;
      out_word_nxt.hit_slot          = tok_in.hit_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= tok_in.vld;
      out_word_r  <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `RTA_ASSERT_IMP(a_drop_only_when_taken, $fell(out_valid_r), $past(!out_stall))
  `RTA_ASSERT_IMP(a_loaded_zero_offset,
                  out_valid_r && out_word_r.status == ST_LOADED,
                  out_word_r.translated_offset == '0)
  `RTA_ASSERT_IMP(a_unmapped_zero,
                  out_valid_r && out_word_r.status == ST_UNMAPPED,
                  out_word_r.translated_offset == '0 && out_word_r.hit_slot == '0)

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for region_table_address_translator: directed table, then random words.
// Depends on rta_pkg and the translator RTL; predicts each result and checks it in order.
`timescale 1ns / 1ps

module testbench;
  import rta_pkg::*;

  localparam int SLOTS        = 16;
  localparam int RANDOM_WORDS = 1000;
  localparam int LONG_HOLD    = 60;
  localparam int STUCK_LIMIT  = 2000;

  typedef struct {
    rta_in_t  word;
    bit       typed;
    rta_out_t want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rta_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  rta_out_t out_word;

  // Shadow copy of the region table
  logic [63:0] reg_lo [SLOTS];
  logic [63:0] reg_len [SLOTS];
  logic [63:0] bk_lo [SLOTS];
  logic [63:0] bk_len [SLOTS];
  bit          slot_live [SLOTS];

  stim_row_t plan [$];
  rta_out_t  result_q [$];
  int        words_sent = 0;
  int        total_words = 0;
  int        loads_sent = 0;
  int        mismatches = 0;
  int        status_seen [4];
  int        stuck_cycles = 0;
  bit        long_hold_done = 1'b0;

  region_table_address_translator #(
    .TABLE_SLOTS (SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // No idling in every third stretch of 150 words, nor over the last 100
  function automatic bit idling_on();
    return (words_sent < total_words - 100) && ((words_sent / 150) % 3 != 2);
  endfunction

  function automatic rta_out_t outcome(rta_status_t st, logic [63:0] off, logic [3:0] slot);
    rta_out_t r;
    r.status            = st;
    r.translated_offset = off;
    r.hit_slot          = slot;
    return r;
  endfunction

  function automatic rta_in_t load_word(logic [3:0] idx, logic [63:0] lo, logic [63:0] len,
                                        logic [63:0] bs, logic [63:0] bl);
    rta_in_t w;
    w.mode           = MODE_LOAD;
    w.entry_index    = idx;
    w.region_start   = lo;
    w.region_length  = len;
    w.backing_start  = bs;
    w.backing_length = bl;
    w.query_address  = rand64();
    return w;
  endfunction

  function automatic rta_in_t lookup_word(logic [63:0] addr);
    rta_in_t w;
    w.mode           = MODE_LOOKUP;
    w.entry_index    = 4'($urandom_range(0, SLOTS - 1));
    w.region_start   = rand64();
    w.region_length  = rand64();
    w.backing_start  = rand64();
    w.backing_length = rand64();
    w.query_address  = addr;
    return w;
  endfunction

  function automatic void add_row(rta_in_t w, bit typed, rta_out_t want);
    stim_row_t row;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  // Apply one word to the shadow table and return the translation it yields
  function automatic rta_out_t translate_word(rta_in_t w);
    rta_out_t    r;
    logic [63:0] top;
    logic [63:0] off;
    logic [63:0] lim;
    r = '0;
    if (w.mode == MODE_LOAD) begin
      if (int'(w.entry_index) < SLOTS) begin
        reg_lo[w.entry_index]    = w.region_start;
        reg_len[w.entry_index]   = w.region_length;
        bk_lo[w.entry_index]     = w.backing_start;
        bk_len[w.entry_index]    = w.backing_length;
        slot_live[w.entry_index] = 1'b1;
      end
      r.status   = ST_LOADED;
      r.hit_slot = w.entry_index;
      return r;
    end
    r.status = ST_UNMAPPED;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i]) begin
        top = reg_lo[i] + reg_len[i];
        // no address meets both bounds of a wrapped or empty range
        if (w.query_address >= reg_lo[i] && w.query_address < top) begin
          off = bk_lo[i] + (w.query_address - reg_lo[i]);
          lim = bk_lo[i] + bk_len[i];
          r.status            = (off + ACCESS_BYTES > lim) ? ST_UNBACKED : ST_OK;
          r.translated_offset = off;
          r.hit_slot          = 4'(i);
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic rta_in_t random_load();
    logic [63:0] lo;
    logic [63:0] len;
    logic [63:0] bs;
    logic [63:0] bl;
    int          j;
    lo  = rand64();
    len = 64'($urandom_range(1, 4096));
    bs  = rand64();
    bl  = 64'($urandom_range(0, 4112));
    case ($urandom_range(0, 9))
      0: begin
        len = rand64();
        bl  = rand64();
      end
      1: lo = ~64'd0 - 64'($urandom_range(0, 4095));
      2: len = '0;
      3: begin
        // overlap a live region
        j = $urandom_range(0, SLOTS - 1);
        if (slot_live[j]) lo = reg_lo[j] + 64'($urandom_range(0, 255));
      end
      4: bs = ~64'd0 - 64'($urandom_range(0, 4095));
      default: ;
    endcase
    return load_word(4'($urandom_range(0, SLOTS - 1)), lo, len, bs, bl);
  endfunction

  function automatic rta_in_t random_lookup();
    logic [63:0] addr;
    int          j;
    j    = $urandom_range(0, SLOTS - 1);
    addr = rand64();
    if (slot_live[j] && reg_len[j] != '0) begin
      case ($urandom_range(0, 7))
        0: addr = reg_lo[j] + reg_len[j];
        1: addr = reg_lo[j] - 64'd1;
        2: addr = reg_lo[j] + reg_len[j] - 64'($urandom_range(1, 16));
        3: ;
        default: addr = reg_lo[j] + rand64() % reg_len[j];
      endcase
    end
    return lookup_word(addr);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one word, hold it until accepted, then queue its expected result
  task automatic send_word(rta_in_t w, bit typed, rta_out_t want);
    rta_out_t predicted;
    if (idling_on() && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = translate_word(w);
    result_q.push_back(typed ? want : predicted);
    if (w.mode == MODE_LOAD) loads_sent++;
    words_sent++;
  endtask

  initial begin : main_flow
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(lookup_word(64'd0), 1'b1, outcome(ST_UNMAPPED, '0, '0));
    add_row(lookup_word(~64'd0), 1'b1, outcome(ST_UNMAPPED, '0, '0));
    add_row(load_word(4'd0, 64'h1000, 64'h100, 64'h5000, 64'h100), 1'b1,
            outcome(ST_LOADED, '0, 4'd0));
    add_row(lookup_word(64'h1000), 1'b1, outcome(ST_OK, 64'h5000, 4'd0));
    // last fully backed word, then one byte past it
    add_row(lookup_word(64'h10F8), 1'b0, '0);
    add_row(lookup_word(64'h10F9), 1'b0, '0);
    add_row(lookup_word(64'h1100), 1'b1, outcome(ST_UNMAPPED, '0, '0));
    add_row(lookup_word(64'h0FFF), 1'b1, outcome(ST_UNMAPPED, '0, '0));
    // range wrapping past the top of the address space
    add_row(load_word(4'd15, ~64'd0 - 64'hFF, 64'h200, 64'd0, ~64'd0), 1'b1,
            outcome(ST_LOADED, '0, 4'd15));
    add_row(lookup_word(64'hFFFF_FFFF_FFFF_FF80), 1'b1, outcome(ST_UNMAPPED, '0, '0));
    add_row(load_word(4'd14, 64'h2000, 64'd0, 64'h10, 64'h10), 1'b1,
            outcome(ST_LOADED, '0, 4'd14));
    add_row(lookup_word(64'h2000), 1'b1, outcome(ST_UNMAPPED, '0, '0));
    // overlap: lower slot wins where both match
    add_row(load_word(4'd1, 64'h1080, 64'h1000, ~64'd0, ~64'd0), 1'b1,
            outcome(ST_LOADED, '0, 4'd1));
    add_row(lookup_word(64'h1080), 1'b0, '0);
    add_row(lookup_word(64'h1200), 1'b0, '0);
    // backed limit that wraps
    add_row(load_word(4'd2, 64'd0, ~64'd0, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20), 1'b1,
            outcome(ST_LOADED, '0, 4'd2));
    add_row(lookup_word(64'd0), 1'b0, '0);
    add_row(lookup_word(64'hFFFF_FFFF_FFFF_FFFE), 1'b0, '0);
    add_row(load_word(4'd3, ~64'd0, 64'd1, 64'd0, 64'd8), 1'b1, outcome(ST_LOADED, '0, 4'd3));
    add_row(lookup_word(~64'd0), 1'b0, '0);
    add_row(load_word(4'd0, 64'h1000, 64'h10, 64'd0, 64'd0), 1'b1,
            outcome(ST_LOADED, '0, 4'd0));
    add_row(lookup_word(64'h1008), 1'b0, '0);
    add_row(load_word(4'd4, 64'h3000, 64'h40, 64'h7000, 64'h40), 1'b0, '0);

    total_words = plan.size() + RANDOM_WORDS;
    foreach (plan[k]) send_word(plan[k].word, plan[k].typed, plan[k].want);
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if ($urandom_range(0, 9) < 3) send_word(random_load(), 1'b0, '0);
      else send_word(random_lookup(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    $display("covered %0d words (%0d loads): %0d translated, %0d unbacked, %0d unmapped",
             words_sent, loads_sent, status_seen[ST_OK], status_seen[ST_UNBACKED],
             status_seen[ST_UNMAPPED]);
    $display("output held off %0d cycles once with input still offered; %0d mismatches",
             LONG_HOLD, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : stall_outputs
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && words_sent >= 400) begin
        // hold long enough to back the chain up into in_stall
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    rta_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = result_q.pop_front();
        status_seen[out_word.status]++;
        if (out_word.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_word.status, want.status));
        if (out_word.translated_offset !== want.translated_offset)
          report_mismatch($sformatf("offset %h, want %h", out_word.translated_offset,
                                    want.translated_offset));
        if (out_word.hit_slot !== want.hit_slot)
          report_mismatch($sformatf("slot %0d, want %0d", out_word.hit_slot, want.hit_slot));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
